### hw/rtl/rafc_pkg.sv
// ----------------------------------------------------------------------------
// rafc_pkg
// Shared types and constants for the first-fit range allocator.
// ----------------------------------------------------------------------------
package rafc_pkg;

    localparam int FREE_SLOTS_DEF = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [31:0] GROW_CHUNK_RST = 32'd10485760;
    localparam logic [31:0] MAX_CAP_RST    = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROW_CHUNK = 1'b0,
        REG_MAX_CAP    = 1'b1
    } rafc_reg_t;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } rafc_func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CAP  = 2'd1,
        ST_FULL = 2'd2
    } rafc_status_t;

    typedef struct packed {
        logic load_in;
        logic alloc_tail;
        logic rd_en;
        logic rd_zero;
        logic scan_chk;
        logic copy_proc;
        logic grow;
        logic tail_ret;
        logic merge_init;
        logic merge_new;
        logic merge_ent;
        logic merge_tail;
        logic merge_flush;
        logic merge_end;
        logic fold_chk;
        logic out_load;
    } rafc_cmd_t;

    typedef struct packed {
        logic is_free;
        logic cnt_zero;
        logic fits;
        logic tret;
        logic empty;
        logic hit;
        logic remove;
        logic last;
        logic place;
        logic ovf;
        logic out_busy;
    } rafc_sts_t;

endpackage

### hw/rtl/range_allocator_first_fit_coalesce_core.sv
// ----------------------------------------------------------------------------
// range_allocator_first_fit_coalesce_core
// First-fit range allocator over one pool with a coalescing free list.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with func, count and offset. An item is
// taken when in_valid is high and in_stall is low. Each item gives exactly
// one result on out_valid / out_stall: start_res, status, grown, free_total.
// Config channel: cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; index 0 is grow_chunk, index 1 is max_capacity.
// One item is in work at a time. The paths from acceptance to out_valid:
//   tail allocate and zero-count free: straight to the result; free back
//   to the tail: a fold check; first-fit scan: a read and a check per
//   list range visited, a grow step if none fits, and a copy of the list
//   when a range is used up and the list is compacted; free into the list:
//   a merge over every range, the new range placed mid-list where it falls,
//   then tail, flush and end steps and a fold check, skipped on overflow.
// The next item can be taken in the cycle after its result is loaded.
// The free list memory is read one range at a time.
// A finished result waits in the output register while the next item is
// taken; if that register is still stalled, the item holds until it drains.
// Reset empties the pool: tail pointer and capacity zero, list empty,
// registers at their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module range_allocator_first_fit_coalesce_core
#(
    parameter int FREE_SLOTS = rafc_pkg::FREE_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rafc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [31:0]                    count,
    input  logic [31:0]                    offset,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    start_res,
    output logic [1:0]                     status,
    output logic                           grown,
    output logic [31:0]                    free_total
);
    import rafc_pkg::*;

    rafc_cmd_t cmd;
    rafc_sts_t sts;

    rafc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rafc_dp #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .count      (count),
        .offset     (offset),
        .cmd        (cmd),
        .sts        (sts),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .start_res  (start_res),
        .status     (status),
        .grown      (grown),
        .free_total (free_total)
    );

endmodule

### hw/rtl/rafc_ctrl.sv
// ----------------------------------------------------------------------------
// rafc_ctrl
// Sequencer: steps items through tail, scan, copy, grow, merge, fold phases.
// ----------------------------------------------------------------------------
module rafc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rafc_pkg::rafc_sts_t sts,
    output rafc_pkg::rafc_cmd_t cmd
);
    import rafc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COPY_RD,
        S_COPY_PROC,
        S_GROW,
        S_MERGE_RD,
        S_MERGE_PROC,
        S_MERGE_TAIL,
        S_MERGE_FLUSH,
        S_MERGE_END,
        S_FOLD_RD,
        S_FOLD_CHK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!sts.is_free)
                begin
                    if (sts.fits)
                    begin
                        cmd.alloc_tail = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (sts.empty)
                        state_next = S_GROW;
                    else
                        state_next = S_SCAN_RD;
                end
                else if (sts.cnt_zero)
                    state_next = S_DONE;
                else if (sts.tret)
                begin
                    cmd.tail_ret = 1'b1;
                    state_next   = S_FOLD_RD;
                end
                else
                begin
                    cmd.merge_init = 1'b1;
                    state_next     = sts.empty ? S_MERGE_TAIL : S_MERGE_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (sts.hit)
                    state_next = sts.remove ? S_COPY_RD : S_DONE;
                else if (sts.last)
                    state_next = S_GROW;
                else
                    state_next = S_SCAN_RD;
            end
            S_COPY_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_COPY_PROC;
            end
            S_COPY_PROC:
            begin
                cmd.copy_proc = 1'b1;
                state_next    = sts.last ? S_DONE : S_COPY_RD;
            end
            S_GROW:
            begin
                cmd.grow   = 1'b1;
                state_next = S_DONE;
            end
            S_MERGE_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_MERGE_PROC;
            end
            S_MERGE_PROC:
            begin
                if (sts.place)
                    cmd.merge_new = 1'b1;
                else
                begin
                    cmd.merge_ent = 1'b1;
                    state_next    = sts.last ? S_MERGE_TAIL : S_MERGE_RD;
                end
            end
            S_MERGE_TAIL:
            begin
                cmd.merge_tail = 1'b1;
                state_next     = S_MERGE_FLUSH;
            end
            S_MERGE_FLUSH:
            begin
                cmd.merge_flush = 1'b1;
                state_next      = S_MERGE_END;
            end
            S_MERGE_END:
            begin
                cmd.merge_end = 1'b1;
                state_next    = sts.ovf ? S_DONE : S_FOLD_RD;
            end
            S_FOLD_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_zero = 1'b1;
                state_next  = S_FOLD_CHK;
            end
            S_FOLD_CHK:
            begin
                cmd.fold_chk = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/rafc_dp.sv
// ----------------------------------------------------------------------------
// rafc_dp
// Datapath: tail pointers, double-banked free list memory, merge logic.
// ----------------------------------------------------------------------------
module rafc_dp
#(
    parameter int FREE_SLOTS = rafc_pkg::FREE_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rafc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           func,
    input  logic [31:0]                    count,
    input  logic [31:0]                    offset,
    input  rafc_pkg::rafc_cmd_t            cmd,
    output rafc_pkg::rafc_sts_t            sts,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [31:0]                    start_res,
    output logic [1:0]                     status,
    output logic                           grown,
    output logic [31:0]                    free_total
);
    import rafc_pkg::*;

    localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int AW = $clog2(2 * FREE_SLOTS);
    localparam int SW = 32 + CW + 1;
    localparam int DEPTH = 2 * FREE_SLOTS;

    logic [31:0] fs_mem [DEPTH];
    logic [31:0] fe_mem [DEPTH];

    logic [31:0] grow_chunk_reg, max_cap_reg;
    logic [31:0] tail_next_reg, tail_end_reg;
    logic [CW-1:0] count_reg, ptr_reg, hidx_reg, wptr_reg;
    logic bank_reg;
    logic [SW-1:0] list_sum_reg, new_sum_reg;
    logic placed_reg, have_reg, ovf_reg;
    logic func_reg;
    logic [31:0] cnt_reg, off_reg, fend_reg;
    logic [31:0] rs_reg, re_reg;
    logic [31:0] acc_s_reg, acc_e_reg;
    logic [31:0] start_reg;
    rafc_status_t status_reg;
    logic grown_reg;
    logic out_valid_reg;
    logic [31:0] out_start_reg, out_total_reg;
    rafc_status_t out_status_reg;
    logic out_grown_reg;

    logic [32:0] in_end;
    logic [31:0] room, len, new_fs, add, ps, pe;
    logic [32:0] cap;
    logic grow_ok, push_new, push, join_acc, emit;
    logic [AW-1:0] raddr, waddr;
    logic we;
    logic [31:0] wd_s, wd_e;
    logic [SW-1:0] tot;

    assign cfg_ready = 1'b1;

    assign in_end = {1'b0, offset} + {1'b0, count};
    assign room   = (tail_end_reg >= tail_next_reg) ? (tail_end_reg - tail_next_reg) : '0;
    assign len    = re_reg - rs_reg;
    assign new_fs = rs_reg + cnt_reg;
    assign add    = (cnt_reg > grow_chunk_reg) ? cnt_reg : grow_chunk_reg;
    assign cap    = {1'b0, tail_end_reg} + {1'b0, add};
    assign grow_ok = (cap <= {1'b0, max_cap_reg});

    assign sts.is_free  = (func_reg == FN_FREE);
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.fits     = (cnt_reg <= room);
    assign sts.tret     = (({1'b0, off_reg} + {1'b0, cnt_reg}) == {1'b0, tail_next_reg});
    assign sts.empty    = (count_reg == '0);
    assign sts.hit      = (len >= cnt_reg);
    assign sts.remove   = (new_fs == re_reg);
    assign sts.last     = (({1'b0, ptr_reg} + 1'b1) == {1'b0, count_reg});
    assign sts.place    = !placed_reg && (off_reg < rs_reg);
    assign sts.ovf      = ovf_reg;
    assign sts.out_busy = out_valid_reg && out_stall;

    assign push_new = cmd.merge_new || (cmd.merge_tail && !placed_reg);
    assign push     = push_new || cmd.merge_ent;
    assign ps       = cmd.merge_ent ? rs_reg : off_reg;
    assign pe       = cmd.merge_ent ? re_reg : fend_reg;
    assign join_acc = have_reg && (ps <= acc_e_reg);
    assign emit     = (push && have_reg && !join_acc) || (cmd.merge_flush && have_reg);

    assign tot = SW'(room) + list_sum_reg;

    always_comb
    begin
        if (cmd.rd_zero)
            raddr = bank_reg ? AW'(FREE_SLOTS) : '0;
        else
            raddr = bank_reg ? AW'(FREE_SLOTS) + AW'(ptr_reg[IW-1:0]) : AW'(ptr_reg[IW-1:0]);
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = bank_reg ? AW'(FREE_SLOTS) + AW'(ptr_reg[IW-1:0]) : AW'(ptr_reg[IW-1:0]);
        wd_s  = new_fs;
        wd_e  = re_reg;
        if (cmd.scan_chk && sts.hit && !sts.remove)
            we = 1'b1;
        else if (cmd.copy_proc && (ptr_reg != hidx_reg))
        begin
            we    = 1'b1;
            waddr = bank_reg ? AW'(wptr_reg[IW-1:0]) : AW'(FREE_SLOTS) + AW'(wptr_reg[IW-1:0]);
            wd_s  = rs_reg;
        end
        else if (emit && (wptr_reg < CW'(FREE_SLOTS)))
        begin
            we    = 1'b1;
            waddr = bank_reg ? AW'(wptr_reg[IW-1:0]) : AW'(FREE_SLOTS) + AW'(wptr_reg[IW-1:0]);
            wd_s  = acc_s_reg;
            wd_e  = acc_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fs_mem[waddr] <= wd_s;
            fe_mem[waddr] <= wd_e;
        end
        if (cmd.rd_en)
        begin
            rs_reg <= fs_mem[raddr];
            re_reg <= fe_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            cnt_reg  <= count;
            off_reg  <= offset;
            fend_reg <= in_end[32] ? 32'hFFFF_FFFF : in_end[31:0];
        end
        if (push)
        begin
            if (join_acc)
            begin
                if (pe > acc_e_reg)
                    acc_e_reg <= pe;
            end
            else
            begin
                acc_s_reg <= ps;
                acc_e_reg <= pe;
            end
        end
        if (cmd.out_load)
        begin
            out_start_reg  <= start_reg;
            out_status_reg <= status_reg;
            out_grown_reg  <= grown_reg;
            out_total_reg  <= (tot > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tot[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_chunk_reg <= GROW_CHUNK_RST;
            max_cap_reg    <= MAX_CAP_RST;
            tail_next_reg  <= '0;
            tail_end_reg   <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            hidx_reg       <= '0;
            wptr_reg       <= '0;
            bank_reg       <= 1'b0;
            list_sum_reg   <= '0;
            new_sum_reg    <= '0;
            placed_reg     <= 1'b0;
            have_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            start_reg      <= '0;
            status_reg     <= ST_OK;
            grown_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GROW_CHUNK: grow_chunk_reg <= cfg_data;
                    REG_MAX_CAP:    max_cap_reg    <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.load_in)
            begin
                start_reg  <= '0;
                status_reg <= ST_OK;
                grown_reg  <= 1'b0;
                ptr_reg    <= '0;
            end
            if (cmd.alloc_tail)
                tail_next_reg <= tail_next_reg + cnt_reg;
            if (cmd.alloc_tail)
                start_reg <= tail_next_reg;
            if (cmd.scan_chk)
            begin
                if (sts.hit)
                begin
                    start_reg <= rs_reg;
                    if (sts.remove)
                    begin
                        hidx_reg <= ptr_reg;
                        ptr_reg  <= '0;
                        wptr_reg <= '0;
                    end
                    else
                        list_sum_reg <= list_sum_reg - SW'(cnt_reg);
                end
                else
                    ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.copy_proc)
            begin
                if (ptr_reg != hidx_reg)
                    wptr_reg <= wptr_reg + 1'b1;
                ptr_reg <= ptr_reg + 1'b1;
                if (sts.last)
                begin
                    bank_reg     <= !bank_reg;
                    count_reg    <= count_reg - 1'b1;
                    list_sum_reg <= list_sum_reg - SW'(cnt_reg);
                end
            end
            if (cmd.grow)
            begin
                if (grow_ok)
                begin
                    tail_end_reg  <= cap[31:0];
                    grown_reg     <= 1'b1;
                    start_reg     <= tail_next_reg;
                    tail_next_reg <= tail_next_reg + cnt_reg;
                end
                else
                    status_reg <= ST_CAP;
            end
            if (cmd.tail_ret)
                tail_next_reg <= off_reg;
            if (cmd.merge_init)
            begin
                placed_reg  <= 1'b0;
                have_reg    <= 1'b0;
                wptr_reg    <= '0;
                new_sum_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            if (push_new)
                placed_reg <= 1'b1;
            if (push)
                have_reg <= 1'b1;
            if (cmd.merge_ent)
                ptr_reg <= ptr_reg + 1'b1;
            if (emit)
            begin
                if (wptr_reg < CW'(FREE_SLOTS))
                    wptr_reg <= wptr_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
                new_sum_reg <= new_sum_reg + SW'(acc_e_reg - acc_s_reg);
            end
            if (cmd.merge_flush)
                have_reg <= 1'b0;
            if (cmd.merge_end)
            begin
                if (ovf_reg)
                    status_reg <= ST_FULL;
                else
                begin
                    bank_reg     <= !bank_reg;
                    count_reg    <= wptr_reg;
                    list_sum_reg <= new_sum_reg;
                end
            end
            if (cmd.fold_chk && (count_reg == CW'(1)) && (re_reg >= tail_next_reg))
            begin
                if (rs_reg < tail_next_reg)
                    tail_next_reg <= rs_reg;
                count_reg    <= '0;
                list_sum_reg <= '0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_res  = out_start_reg;
    assign status     = out_status_reg;
    assign grown      = out_grown_reg;
    assign free_total = out_total_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FREE_SLOTS))
        else $error("free list count exceeds slots");

    a_cap_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && (status_reg == ST_CAP) |-> !grown_reg && (start_reg == '0))
        else $error("capacity error with grown or start set");

    a_commit_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_end && !ovf_reg |=> (count_reg == $past(wptr_reg))
            || (count_reg == '0))
        else $error("merge commit count mismatch");
`endif

endmodule

### sim/range_allocator_first_fit_coalesce_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_allocator_first_fit_coalesce_core_tb
// Self-checking bench for the first-fit range allocator. A queue of requests
// feeds a clocked driver; a clocked monitor predicts each accepted request
// against its own pool model and compares every result field. Both sides
// idle in random bursts outside two phases, over several register settings.
// ----------------------------------------------------------------------------
module range_allocator_first_fit_coalesce_core_tb;

    import rafc_pkg::*;

    localparam int NSLOT     = FREE_SLOTS_DEF;
    localparam int LIMIT     = 900000;
    localparam int MAX_LIVE  = 48;

    typedef struct packed {
        logic [31:0]            chunk;
        logic [31:0]            maxcap;
        logic [31:0]            tnext;
        logic [31:0]            tend;
        logic [NSLOT-1:0][31:0] fs;
        logic [NSLOT-1:0][31:0] fe;
        logic [4:0]             fcnt;
    } pool_t;

    typedef struct packed {
        logic [31:0] start;
        logic [1:0]  st;
        logic        grw;
        logic [31:0] total;
    } outcome_t;

    typedef struct packed {
        logic        fn;
        logic [31:0] cnt;
        logic [31:0] off;
    } req_t;

    typedef struct packed {
        logic [31:0] s;
        logic [31:0] c;
    } blk_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [31:0] count;
    logic [31:0] offset;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] start_res;
    logic [1:0]  status;
    logic        grown;
    logic [31:0] free_total;

    pool_t    gen_pool;
    pool_t    chk_pool;
    req_t     pending_q[$];
    outcome_t expected_q[$];
    blk_t     live_q[$];
    int       mismatches;
    int       cycles;
    int       in_gap;
    int       out_hold;
    logic     idle_on;
    logic     in_taken;

    range_allocator_first_fit_coalesce_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .count      (count),
        .offset     (offset),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .start_res  (start_res),
        .status     (status),
        .grown      (grown),
        .free_total (free_total)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic void pool_reset(output pool_t p);
        p        = '0;
        p.chunk  = GROW_CHUNK_RST;
        p.maxcap = MAX_CAP_RST;
    endfunction

    function automatic void fold_tail(inout pool_t p);
        if (p.fcnt == 5'd1 && p.fe[0] >= p.tnext)
        begin
            if (p.fs[0] < p.tnext)
                p.tnext = p.fs[0];
            p.fcnt = '0;
        end
    endfunction

    function automatic void alloc_step(inout pool_t p, input logic fn,
                                       input logic [31:0] cnt,
                                       input logic [31:0] off,
                                       output outcome_t r);
        logic [31:0] room;
        logic [31:0] add;
        logic [31:0] last;
        logic [63:0] cap;
        logic [63:0] e64;
        logic [63:0] t;
        logic [31:0] ts[0:NSLOT];
        logic [31:0] te[0:NSLOT];
        logic [31:0] ms[0:NSLOT];
        logic [31:0] me[0:NSLOT];
        logic        hit;
        logic        placed;
        int          i;
        int          k;
        int          n;
        int          m;
        r = '0;
        r.st = ST_OK;
        if (fn == FN_ALLOC)
        begin
            room = (p.tend >= p.tnext) ? p.tend - p.tnext : 32'd0;
            if (cnt <= room)
            begin
                r.start = p.tnext;
                p.tnext = p.tnext + cnt;
            end
            else
            begin
                hit = 1'b0;
                for (i = 0; i < NSLOT; i++)
                begin
                    if (!hit && i < int'(p.fcnt) && p.fe[i] - p.fs[i] >= cnt)
                    begin
                        r.start  = p.fs[i];
                        p.fs[i]  = p.fs[i] + cnt;
                        if (p.fs[i] == p.fe[i])
                        begin
                            for (k = i; k < NSLOT - 1; k++)
                            begin
                                if (k + 1 < int'(p.fcnt))
                                begin
                                    p.fs[k] = p.fs[k+1];
                                    p.fe[k] = p.fe[k+1];
                                end
                            end
                            p.fcnt = p.fcnt - 5'd1;
                        end
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    add = (cnt > p.chunk) ? cnt : p.chunk;
                    cap = {32'd0, p.tend} + {32'd0, add};
                    if (cap > {32'd0, p.maxcap})
                        r.st = ST_CAP;
                    else
                    begin
                        p.tend  = cap[31:0];
                        r.grw   = 1'b1;
                        r.start = p.tnext;
                        p.tnext = p.tnext + cnt;
                    end
                end
            end
        end
        else if (cnt != 32'd0)
        begin
            e64  = {32'd0, off} + {32'd0, cnt};
            last = e64[32] ? 32'hFFFF_FFFF : e64[31:0];
            if (e64 == {32'd0, p.tnext})
            begin
                p.tnext = off;
                fold_tail(p);
            end
            else
            begin
                n = 0;
                placed = 1'b0;
                for (i = 0; i < int'(p.fcnt); i++)
                begin
                    if (!placed && off < p.fs[i])
                    begin
                        ts[n] = off;
                        te[n] = last;
                        n++;
                        placed = 1'b1;
                    end
                    ts[n] = p.fs[i];
                    te[n] = p.fe[i];
                    n++;
                end
                if (!placed)
                begin
                    ts[n] = off;
                    te[n] = last;
                    n++;
                end
                m = 0;
                for (i = 0; i < n; i++)
                begin
                    if (m > 0 && ts[i] <= me[m-1])
                    begin
                        if (te[i] > me[m-1])
                            me[m-1] = te[i];
                    end
                    else
                    begin
                        ms[m] = ts[i];
                        me[m] = te[i];
                        m++;
                    end
                end
                if (m > NSLOT)
                    r.st = ST_FULL;
                else
                begin
                    for (i = 0; i < m; i++)
                    begin
                        p.fs[i] = ms[i];
                        p.fe[i] = me[i];
                    end
                    p.fcnt = m[4:0];
                    fold_tail(p);
                end
            end
        end
        t = (p.tend >= p.tnext) ? {32'd0, p.tend - p.tnext} : 64'd0;
        for (i = 0; i < int'(p.fcnt); i++)
            t = t + {32'd0, p.fe[i] - p.fs[i]};
        r.total = (t > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    task automatic push_req(input logic fn, input logic [31:0] cnt,
                            input logic [31:0] off);
        outcome_t r;
        blk_t     b;
        req_t     rq;
        alloc_step(gen_pool, fn, cnt, off, r);
        rq.fn  = fn;
        rq.cnt = cnt;
        rq.off = off;
        pending_q.insert(pending_q.size(), rq);
        if (fn == FN_ALLOC && r.st == ST_OK && cnt != 32'd0)
        begin
            b.s = r.start;
            b.c = cnt;
            live_q.insert(live_q.size(), b);
        end
    endtask

    task automatic free_live(input int idx);
        blk_t b;
        b = live_q[idx];
        live_q.delete(idx);
        push_req(FN_FREE, b.c, b.s);
    endtask

    task automatic random_reqs(input int n);
        int          i;
        int          pick;
        logic [31:0] cnt;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (live_q.size() > 0 && (pick < 40 || live_q.size() >= MAX_LIVE))
                free_live($urandom_range(0, live_q.size() - 1));
            else if (pick < 94)
            begin
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 5000)
                                                   : $urandom_range(1, 48);
                push_req(FN_ALLOC, cnt, $urandom);
            end
            else if (pick < 97)
                push_req($urandom_range(0, 1), $urandom, $urandom);
            else
                push_req($urandom_range(0, 1), $urandom_range(0, 1),
                         gen_pool.tnext - $urandom_range(0, 3));
        end
    endtask

    task automatic fragment_burst();
        int i;
        int base;
        base = live_q.size();
        for (i = 0; i < 36; i++)
            push_req(FN_ALLOC, 32'd2, 32'd0);
        for (i = 0; i < 18; i++)
        begin
            if (base + i < live_q.size())
                free_live(base + i);
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input rafc_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_GROW_CHUNK)
            gen_pool.chunk = val;
        else
            gen_pool.maxcap = val;
    endtask

    task automatic set_regs(input logic [31:0] chunk, input logic [31:0] cap);
        wait_idle();
        write_reg(REG_GROW_CHUNK, chunk);
        write_reg(REG_MAX_CAP, cap);
    endtask

    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                in_gap   <= $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                func     <= pending_q[0].fn;
                count    <= pending_q[0].cnt;
                offset   <= pending_q[0].off;
                in_valid <= 1'b1;
                void'(pending_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
        if (out_hold > 0)
        begin
            out_hold  <= out_hold - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_hold  <= $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        outcome_t r;
        outcome_t e;
        in_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GROW_CHUNK)
                    chk_pool.chunk = cfg_data;
                else
                    chk_pool.maxcap = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result start=%h status=%0d grown=%0d total=%h",
                                 start_res, status, grown, free_total);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (start_res !== e.start || status !== e.st || grown !== e.grw
                        || free_total !== e.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp start=%h st=%0d gr=%0d tot=%h / act %h %0d %0d %h",
                                     e.start, e.st, e.grw, e.total,
                                     start_res, status, grown, free_total);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                alloc_step(chk_pool, func, count, offset, r);
                expected_q.insert(expected_q.size(), r);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] a;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_GROW_CHUNK;
        cfg_data   = '0;
        in_valid   = 1'b0;
        func       = FN_ALLOC;
        count      = '0;
        offset     = '0;
        out_stall  = 1'b0;
        in_gap     = 0;
        out_hold   = 0;
        in_taken   = 1'b0;
        idle_on    = 1'b1;
        mismatches = 0;
        cycles     = 0;
        pool_reset(gen_pool);
        pool_reset(chk_pool);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_req(FN_ALLOC, 32'd0, 32'hFFFF_FFFF);
        push_req(FN_ALLOC, 32'd1, 32'd0);
        push_req(FN_ALLOC, 32'hFFFF_FFFF, 32'd0);
        push_req(FN_ALLOC, 32'd5, 32'd0);
        a = gen_pool.tnext;
        push_req(FN_ALLOC, 32'd7, 32'd0);
        push_req(FN_ALLOC, 32'd3, 32'd0);
        push_req(FN_FREE, 32'd5, a - 32'd5);
        push_req(FN_FREE, 32'd0, 32'd1);
        push_req(FN_FREE, 32'd3, gen_pool.tnext - 32'd3);
        push_req(FN_ALLOC, 32'd4, 32'd0);
        push_req(FN_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(FN_FREE, 32'h10, 32'h8000_0000);
        push_req(FN_FREE, 32'd1, 32'd0);
        push_req(FN_ALLOC, 32'h8000_0000, 32'd0);
        live_q.delete();
        random_reqs(180);

        set_regs(32'd1, 32'hFFFF_FFFF);
        fragment_burst();
        random_reqs(200);

        idle_on = 1'b0;
        set_regs(32'd64, gen_pool.tend + 32'd2000);
        random_reqs(150);
        idle_on = 1'b1;
        random_reqs(100);

        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_reqs(150);

        set_regs(32'd16, 32'd1);
        fragment_burst();
        random_reqs(130);

        idle_on = 1'b0;
        set_regs(GROW_CHUNK_RST, MAX_CAP_RST);
        random_reqs(250);

        wait_idle();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
